FILE: rtl/temp_page_slot_allocator_top_macros.svh
// Assertion macros for the temporary page slot allocator.
// Each use sits at the end of a module that has clk and rst_n in scope.
`ifndef TEMP_PAGE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define TEMP_PAGE_SLOT_ALLOCATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define TPSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpsa assertion failed");
// Check a property on every clock edge, reset included.
`define TPSA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpsa assertion failed");
`else
`define TPSA_ASSERT(lbl, prop)
`define TPSA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/tpsa_pkg.sv
package tpsa_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [31:0]           PAGE_BYTES  = 32'h0000_1000;
  localparam logic [11:0]           OFFSET_MASK = 12'hFFF;
  localparam logic [31:0]           ENTRY_FLAGS = 32'h0000_0003;
  localparam logic [31:0]           TABLE_BASE  = 32'hFFC0_0000;
  localparam logic [31:0]           TOP_RESET   = 32'hFF80_0000;
  localparam logic [31:0]           WINDOW_SPAN = 32'((SLOT_COUNT - 1) * 4096);
  localparam logic [SLOT_COUNT-1:0] ALL_FREE    = {SLOT_COUNT{1'b1}};
  localparam logic [SLOT_W-1:0]     LAST_SLOT   = SLOT_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_MAPPED       = 3'd0,
    ST_RELEASED     = 3'd1,
    ST_UNALIGNED    = 3'd2,
    ST_FULL         = 3'd3,
    ST_OUTSIDE      = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_SCAN,
    S_REL_DIFF,
    S_REL_LIMIT,
    S_REL_CHECK,
    S_ENTRY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] mapped_address;
    logic [3:0]  slot_number;
    logic        entry_write;
    logic [31:0] entry_address;
    logic [31:0] entry_value;
  } out_word_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        borrow;
  } alu_rsp_t;

endpackage

FILE: rtl/tpsa_alu.sv
module tpsa_alu import tpsa_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] total;

  // a + b, or a - b as a + ~b + 1; borrow when a < b on subtract
  assign total = {1'b0, req.a} + {1'b0, req.b ^ {32{req.sub}}} + 33'(req.sub);

  assign rsp.sum    = total[31:0];
  assign rsp.borrow = req.sub & ~total[32];

endmodule

FILE: rtl/tpsa_core.sv
`include "temp_page_slot_allocator_top_macros.svh"

module tpsa_core import tpsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  in_word_t    in_word,
  output logic        in_take,
  output logic        res_valid,
  output out_word_t   res_word,
  input  logic        res_ready
);

  state_t                state_r, state_nxt;
  logic [SLOT_COUNT-1:0] free_r;
  logic [31:0]           top_r;
  logic                  mode_r;
  logic [31:0]           addr_r;
  logic [31:0]           work_r;
  logic [SLOT_W-1:0]     idx_r;
  out_word_t             res_r;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [31:0]           idx_ext;
  logic [31:0]           entry_src;
  logic                  push;

  tpsa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  function automatic out_word_t err_word(input status_t st);
    out_word_t w;
    w        = '0;
    w.status = st;
    return w;
  endfunction

  assign idx_ext   = 32'(idx_r);
  assign entry_src = mode_r ? addr_r : work_r;
  assign push      = res_valid & res_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_word.mode) state_nxt = S_REL_DIFF;
          else if ((in_word.address[11:0] & OFFSET_MASK) != '0) state_nxt = S_FIN;
          else state_nxt = S_MAP_SCAN;
        end
      end
      S_MAP_SCAN: begin
        if (free_r[idx_r]) state_nxt = S_ENTRY;
        else if (idx_r == LAST_SLOT) state_nxt = S_FIN;
      end
      S_REL_DIFF:  state_nxt = alu_rsp.borrow ? S_FIN : S_REL_LIMIT;
      S_REL_LIMIT: state_nxt = alu_rsp.borrow ? S_FIN : S_REL_CHECK;
      S_REL_CHECK: state_nxt = free_r[idx_r] ? S_FIN : S_ENTRY;
      S_ENTRY:     state_nxt = S_FIN;
      S_FIN:       state_nxt = res_ready ? S_IDLE : S_FIN;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Outputs and shared adder operands
  always_comb begin
    alu_req   = '0;
    in_take   = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: in_take = 1'b1;
      S_MAP_SCAN: begin
        alu_req.a   = work_r;
        alu_req.b   = PAGE_BYTES;
        alu_req.sub = 1'b1;
      end
      S_REL_DIFF: begin
        alu_req.a   = top_r;
        alu_req.b   = addr_r;
        alu_req.sub = 1'b1;
      end
      S_REL_LIMIT: begin
        alu_req.a   = WINDOW_SPAN;
        alu_req.b   = work_r;
        alu_req.sub = 1'b1;
      end
      S_ENTRY: begin
        alu_req.a   = TABLE_BASE;
        alu_req.b   = {10'b0, entry_src[31:12], 2'b00};
        alu_req.sub = 1'b0;
      end
      S_FIN:   res_valid = 1'b1;
      default: alu_req = '0;
    endcase
  end

  assign res_word = res_r;

  // Control state, window register and free bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= ALL_FREE;
      top_r   <= TOP_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) top_r <= cfg_wr_data;
      if (push && res_r.status == ST_MAPPED) free_r[idx_r] <= 1'b0;
      if (push && res_r.status == ST_RELEASED) free_r[idx_r] <= 1'b1;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_r <= in_word.mode;
          addr_r <= in_word.address;
          work_r <= top_r;
          idx_r  <= '0;
          res_r  <= err_word(ST_UNALIGNED);
        end
      end
      S_MAP_SCAN: begin
        if (!free_r[idx_r]) begin
          if (idx_r == LAST_SLOT) begin
            res_r <= err_word(ST_FULL);
          end else begin
            idx_r  <= idx_r + SLOT_W'(1);
            work_r <= alu_rsp.sum;
          end
        end
      end
      S_REL_DIFF: begin
        if (alu_rsp.borrow) res_r <= err_word(ST_OUTSIDE);
        else work_r <= alu_rsp.sum;
      end
      S_REL_LIMIT: begin
        if (alu_rsp.borrow) res_r <= err_word(ST_OUTSIDE);
        else idx_r <= work_r[12 +: SLOT_W];
      end
      S_REL_CHECK: begin
        if (free_r[idx_r]) res_r <= err_word(ST_ALREADY_FREE);
      end
      S_ENTRY: begin
        res_r.status         <= mode_r ? ST_RELEASED : ST_MAPPED;
        res_r.mapped_address <= mode_r ? 32'd0 : work_r;
        res_r.slot_number    <= idx_ext[3:0];
        res_r.entry_write    <= 1'b1;
        res_r.entry_address  <= alu_rsp.sum;
        res_r.entry_value    <= mode_r ? 32'd0 : (addr_r | ENTRY_FLAGS);
      end
      default: res_r <= res_r;
    endcase
  end

  `TPSA_ASSERT(a_map_claims_slot,
    (push && res_r.status == ST_MAPPED) |=> !free_r[$past(idx_r)])
  `TPSA_ASSERT(a_bitmap_moves_on_push, !push |=> $stable(free_r))
  `TPSA_ASSERT(a_error_fields_zero,
    (res_valid && !res_r.entry_write) |->
      (res_r.mapped_address == 32'd0 && res_r.entry_address == 32'd0 &&
       res_r.slot_number == 4'd0))
  `TPSA_ASSERT_ALWAYS(a_take_only_idle, in_take |-> !res_valid)

endmodule

FILE: rtl/temp_page_slot_allocator_top.sv
// Temporary page slot allocator: hands out and takes back 4 KiB virtual slots
// in a window that ends at window_top_address (slot n lies n pages below it).
// Input channel (in_valid/in_stall, in_word): mode 0 maps the physical page in
//   in_word.address to the lowest free slot; mode 1 releases the slot that a
//   virtual address in the window falls in.
// Result channel (out_valid/out_stall, out_word): one word per request with a
//   status code, the mapped address, the slot and the page-table entry write
//   (address and value) that the caller performs along with a TLB invalidate.
// Configuration: cfg_wr_en/cfg_wr_data write window_top_address; write it only
//   while no request is in flight.
// Sequencing: one request at a time, one shared 32-bit adder under a sequencer.
//   A map scans one bitmap slot per cycle from slot 0, stepping the address by
//   one page; a release checks the offset below the window top, the window span
//   and the slot's bit; an unaligned map goes straight to the result. The next word is
//   taken the cycle after the result moves out; in_stall is low only while idle.
// Reset (rst_n low, synchronous): all slots free, window top back to
//   0xFF800000, no result pending.
// out_stall holds the result word in the output register; one finished word
//   may wait there while the next request is worked on, and that request then
//   waits in its last step until the register frees.
module temp_page_slot_allocator_top import tpsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  logic      in_take;
  logic      res_valid;
  logic      res_ready;
  out_word_t res_word;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  tpsa_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_word     (in_word),
    .in_take     (in_take),
    .res_valid   (res_valid),
    .res_word    (res_word),
    .res_ready   (res_ready)
  );

  // Stall the input while the sequencer works on a request
  assign in_stall = ~in_take;

  // Load the output register when it is empty or its word leaves this cycle
  assign res_ready = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) out_valid_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the word while stalled
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_word_r <= res_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
